// ----- rtl/core/psl_pkg.sv -----
// ----------------------------------------------------------------------------
// psl_pkg
// Shared widths, register indexes, reset values and beat types of the PID
// speed loop with conditional-integration anti-windup.
// ----------------------------------------------------------------------------
package psl_pkg;

    // Field and datapath widths
    localparam int IN_W       = 17;                          // Q9.8 speed
    localparam int ERR_W      = IN_W + 1;                    // speed difference
    localparam int DERR_W     = ERR_W + 1;                   // error difference
    localparam int GAIN_W     = 24;                          // unsigned Q16.8
    localparam int LIM_W      = 13;                          // whole PWM counts
    localparam int FRAC_W     = 8;
    localparam int PTERM_W    = GAIN_W + ERR_W + 1 - FRAC_W;
    localparam int DTERM_W    = GAIN_W + DERR_W + 1 - FRAC_W;
    localparam int ITERM_W    = PTERM_W;
    localparam int PD_W       = DTERM_W + 1;                 // P + D
    localparam int SUM_W      = PD_W + 1;                    // P + D + I
    localparam int ACC_W      = 23;                          // integral, Q.8
    localparam int IACC_W     = ITERM_W + 1;                 // integral + step
    localparam int DRIVE_W    = 23;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Register reset values
    localparam logic [GAIN_W-1:0] GAIN_PROP_RST = 24'd204800;
    localparam logic [GAIN_W-1:0] GAIN_INT_RST  = 24'd256000;
    localparam logic [GAIN_W-1:0] GAIN_DER_RST  = 24'd256;
    localparam logic [LIM_W-1:0]  DRIVE_LIM_RST = 13'd4200;
    localparam logic [LIM_W-1:0]  INT_LIM_RST   = 13'd1000;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_PROP      = 3'd0,
        REG_GAIN_INTEGRAL  = 3'd1,
        REG_GAIN_DERIV     = 3'd2,
        REG_DRIVE_LIMIT    = 3'd3,
        REG_INTEGRAL_LIMIT = 3'd4
    } t_reg_idx;

    // Configuration register file contents
    typedef struct packed {
        logic [GAIN_W-1:0] gain_prop;
        logic [GAIN_W-1:0] gain_integral;
        logic [GAIN_W-1:0] gain_deriv;
        logic [LIM_W-1:0]  drive_limit;
        logic [LIM_W-1:0]  integral_limit;
    } t_cfg;

    // One input beat as held in the input register
    typedef struct packed {
        logic signed [IN_W-1:0] target_speed;
        logic signed [IN_W-1:0] measured_speed;
        logic                   clear;
    } t_sample;

    // Scaled terms handed from the multiply stage to the P+D sum stage
    typedef struct packed {
        logic signed [PTERM_W-1:0] pterm;
        logic signed [DTERM_W-1:0] dterm;
        logic signed [ITERM_W-1:0] iterm;
        logic                      err_pos;
        logic                      err_neg;
        logic                      clear;
    } t_prod;

endpackage

// ----- rtl/core/psl_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// psl_cfg_regs
// Gain and limit registers; writes to an index beyond the list are dropped.
// ----------------------------------------------------------------------------
module psl_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_wr_en,
    input  logic [psl_pkg::CFG_IDX_W-1:0]   i_wr_index,
    input  logic [psl_pkg::CFG_DATA_W-1:0]  i_wr_data,
    output psl_pkg::t_cfg                   o_cfg
);

    psl_pkg::t_cfg r_cfg;
    psl_pkg::t_cfg n_cfg;

    // Decode the register index
    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            case (psl_pkg::t_reg_idx'(i_wr_index))
                psl_pkg::REG_GAIN_PROP: begin
                    n_cfg.gain_prop = i_wr_data[psl_pkg::GAIN_W-1:0];
                end
                psl_pkg::REG_GAIN_INTEGRAL: begin
                    n_cfg.gain_integral = i_wr_data[psl_pkg::GAIN_W-1:0];
                end
                psl_pkg::REG_GAIN_DERIV: begin
                    n_cfg.gain_deriv = i_wr_data[psl_pkg::GAIN_W-1:0];
                end
                psl_pkg::REG_DRIVE_LIMIT: begin
                    n_cfg.drive_limit = i_wr_data[psl_pkg::LIM_W-1:0];
                end
                psl_pkg::REG_INTEGRAL_LIMIT: begin
                    n_cfg.integral_limit = i_wr_data[psl_pkg::LIM_W-1:0];
                end
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_prop      <= psl_pkg::GAIN_PROP_RST;
            r_cfg.gain_integral  <= psl_pkg::GAIN_INT_RST;
            r_cfg.gain_deriv     <= psl_pkg::GAIN_DER_RST;
            r_cfg.drive_limit    <= psl_pkg::DRIVE_LIM_RST;
            r_cfg.integral_limit <= psl_pkg::INT_LIM_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/core/psl_front.sv -----
// ----------------------------------------------------------------------------
// psl_front
// Error, error difference and the three gain products, registered.
// Keeps the previous error for the derivative term.
// ----------------------------------------------------------------------------
module psl_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  psl_pkg::t_sample  i_sample,
    input  psl_pkg::t_cfg     i_cfg,
    output psl_pkg::t_prod    o_prod
);

    localparam int PW = psl_pkg::GAIN_W + psl_pkg::ERR_W + 1;
    localparam int DW = psl_pkg::GAIN_W + psl_pkg::DERR_W + 1;

    logic signed [psl_pkg::ERR_W-1:0]  r_prev_error;
    logic signed [psl_pkg::ERR_W-1:0]  err;
    logic signed [psl_pkg::DERR_W-1:0] derr;
    logic signed [PW-1:0]              p_full;
    logic signed [DW-1:0]              d_full;
    logic signed [PW-1:0]              i_full;
    psl_pkg::t_prod                    n_prod;
    psl_pkg::t_prod                    r_prod;

    // Error and its change since the last tick
    assign err  = psl_pkg::ERR_W'(i_sample.target_speed)
                - psl_pkg::ERR_W'(i_sample.measured_speed);
    assign derr = psl_pkg::DERR_W'(err) - psl_pkg::DERR_W'(r_prev_error);

    // Gain products, Q.16; dropping 8 bits of a signed value floors
    assign p_full = $signed({1'b0, i_cfg.gain_prop}) * err;
    assign d_full = $signed({1'b0, i_cfg.gain_deriv}) * derr;
    assign i_full = $signed({1'b0, i_cfg.gain_integral}) * err;

    always_comb begin
        n_prod.pterm   = p_full[PW-1:psl_pkg::FRAC_W];
        n_prod.dterm   = d_full[DW-1:psl_pkg::FRAC_W];
        n_prod.iterm   = i_full[PW-1:psl_pkg::FRAC_W];
        n_prod.err_neg = err[psl_pkg::ERR_W-1];
        n_prod.err_pos = !err[psl_pkg::ERR_W-1] && (err != '0);
        n_prod.clear   = i_sample.clear;
    end

    // Error history advances with each beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_error <= '0;
        end else if (i_load) begin
            r_prev_error <= i_sample.clear ? '0 : err;
        end
    end

    // Product register
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;

endmodule

// ----- rtl/core/psl_back.sv -----
// ----------------------------------------------------------------------------
// psl_back
// P+D sum register, then the integrator with its hold and clamp, and the
// clamped drive in the result register.
// ----------------------------------------------------------------------------
module psl_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_load_sum,
    input  logic                                 i_load_out,
    input  psl_pkg::t_prod                       i_prod,
    input  psl_pkg::t_cfg                        i_cfg,
    output logic signed [psl_pkg::DRIVE_W-1:0]   o_drive
);

    localparam int SUM_W  = psl_pkg::SUM_W;
    localparam int IACC_W = psl_pkg::IACC_W;
    localparam int ACC_W  = psl_pkg::ACC_W;

    // Sum stage
    logic signed [psl_pkg::PD_W-1:0]    r_pd;
    logic signed [psl_pkg::ITERM_W-1:0] r_iterm;
    logic                               r_err_pos;
    logic                               r_err_neg;
    logic                               r_clear;

    // Integrator and result
    logic signed [ACC_W-1:0]            r_acc;
    logic signed [ACC_W-1:0]            n_acc;
    logic signed [psl_pkg::DRIVE_W-1:0] r_drive;
    logic signed [psl_pkg::DRIVE_W-1:0] n_drive;

    logic signed [ACC_W-1:0]            ilim;
    logic signed [ACC_W-1:0]            olim;
    logic signed [SUM_W-1:0]            preclip;
    logic                               hold;
    logic signed [IACC_W-1:0]           acc_sum;
    logic signed [ACC_W-1:0]            acc_clamp;
    logic signed [SUM_W-1:0]            drive_sum;

    // Limits in Q.8
    assign ilim = $signed({2'b00, i_cfg.integral_limit, 8'h00});
    assign olim = $signed({2'b00, i_cfg.drive_limit, 8'h00});

    always_ff @(posedge i_clk) begin
        if (i_load_sum) begin
            r_pd      <= psl_pkg::PD_W'(i_prod.pterm) + psl_pkg::PD_W'(i_prod.dterm);
            r_iterm   <= i_prod.iterm;
            r_err_pos <= i_prod.err_pos;
            r_err_neg <= i_prod.err_neg;
            r_clear   <= i_prod.clear;
        end
    end

    // Integrate unless it would deepen saturation
    assign preclip = SUM_W'(r_pd) + SUM_W'(r_acc);

    assign hold = (r_acc >= ilim && r_err_pos)
               || (r_acc <= -ilim && r_err_neg)
               || (preclip >= SUM_W'(olim) && r_err_pos)
               || (preclip <= -SUM_W'(olim) && r_err_neg);

    assign acc_sum = hold ? IACC_W'(r_acc) : IACC_W'(r_acc) + IACC_W'(r_iterm);

    always_comb begin
        if (acc_sum >= IACC_W'(ilim)) begin
            acc_clamp = ilim;
        end else if (acc_sum <= -IACC_W'(ilim)) begin
            acc_clamp = -ilim;
        end else begin
            acc_clamp = acc_sum[ACC_W-1:0];
        end
    end

    // Output clamp
    assign drive_sum = SUM_W'(r_pd) + SUM_W'(acc_clamp);

    always_comb begin
        if (drive_sum >= SUM_W'(olim)) begin
            n_drive = olim;
        end else if (drive_sum <= -SUM_W'(olim)) begin
            n_drive = -olim;
        end else begin
            n_drive = drive_sum[psl_pkg::DRIVE_W-1:0];
        end
        n_acc = acc_clamp;
        if (r_clear) begin
            n_drive = '0;
            n_acc   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_load_out) begin
            r_acc <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load_out) begin
            r_drive <= n_drive;
        end
    end

    assign o_drive = r_drive;

    // A cleared beat leaves zero drive and an empty integrator
    a_clear_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load_out && r_clear |=> (r_drive == '0) && (r_acc == '0))
        else $error("clear did not zero drive and integrator");

    // Drive stays inside the output clamp
    a_drive_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load_out |=> (r_drive <= olim) && (r_drive >= -olim))
        else $error("drive outside clamp");

    // Integrator only moves with a beat
    a_acc_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_load_out |=> $stable(r_acc))
        else $error("integrator changed without a beat");

endmodule

// ----- rtl/core/pid_speed_loop_cond_antiwindup_unit.sv -----
// ----------------------------------------------------------------------------
// pid_speed_loop_cond_antiwindup_unit
// Positional PID speed loop with conditional-integration anti-windup.
// ----------------------------------------------------------------------------
// The unit takes one beat per clock while no stall backs up to its input,
// and returns the drive for each beat through a four-register pipeline:
// input register, gain products, P+D sum, and integrator with clamped
// result. The rate of one beat per cycle is set by the integrator update,
// which closes within the last stage. Each stage moves on its own, so the
// unit keeps taking beats while a result waits at a stalled output until
// all four registers are full. Configuration writes are always ready and
// must only be issued while no beat is in flight.
module pid_speed_loop_cond_antiwindup_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Configuration write channel
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [psl_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [psl_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    // Input channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [psl_pkg::IN_W-1:0]      i_target_speed,
    input  logic signed [psl_pkg::IN_W-1:0]      i_measured_speed,
    input  logic                                 i_clear,
    // Output channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [psl_pkg::DRIVE_W-1:0]   o_drive
);

    psl_pkg::t_cfg    cfg;
    psl_pkg::t_sample r_sample;
    psl_pkg::t_prod   prod;

    logic r_v1;
    logic r_v2;
    logic r_v3;
    logic r_out_valid;
    logic rdy1;
    logic rdy2;
    logic rdy3;
    logic rdy4;
    logic load_in;
    logic mv1;
    logic mv2;
    logic mv3;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    psl_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid && o_cfg_ready),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    // Stage flow: a stage takes a beat when it is empty or its beat moves on
    assign rdy4    = !r_out_valid || !i_out_stall;
    assign rdy3    = !r_v3 || rdy4;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign load_in = i_in_valid && rdy1;
    assign mv1     = r_v1 && rdy2;
    assign mv2     = r_v2 && rdy3;
    assign mv3     = r_v3 && rdy4;

    assign o_in_stall = !rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_v1        <= load_in || (r_v1 && !mv1);
            r_v2        <= mv1 || (r_v2 && !mv2);
            r_v3        <= mv2 || (r_v3 && !mv3);
            r_out_valid <= mv3 || (r_out_valid && !rdy4);
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (load_in) begin
            r_sample.target_speed   <= i_target_speed;
            r_sample.measured_speed <= i_measured_speed;
            r_sample.clear          <= i_clear;
        end
    end

    psl_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (mv1),
        .i_sample (r_sample),
        .i_cfg    (cfg),
        .o_prod   (prod)
    );

    psl_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load_sum (mv2),
        .i_load_out (mv3),
        .i_prod     (prod),
        .i_cfg      (cfg),
        .o_drive    (o_drive)
    );

    assign o_out_valid = r_out_valid;

    // Input stalls only with every stage occupied
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_v1 && r_v2 && r_v3 && r_out_valid))
        else $error("input stalled with an empty stage");

    // A taken result with nothing behind it empties the output
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_stall && !r_v3) |=> !r_out_valid)
        else $error("result repeated");

    // A finished beat reaches the output when it is free
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && rdy4) |=> r_out_valid)
        else $error("result lost");

endmodule

// ----- tb/pid_speed_loop_cond_antiwindup_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_speed_loop_cond_antiwindup_unit_tb
// Self-checking bench for the PID speed loop. A cycle-free model of the loop
// (error, P/I/D terms, conditional integration, clamps, clear) predicts the
// drive of every accepted beat. Each returned beat is checked in order
// against it. Directed beats cover extremes, windup, clear and zero limits.
// Random phases follow under several register settings, all but one with
// random gaps and output stalls.
// ----------------------------------------------------------------------------
module pid_speed_loop_cond_antiwindup_unit_tb;

    localparam int NUM_REGS     = 5;      // indexes at or above this are unused
    localparam int DRAIN_CYCLES = 6;      // pipeline depth plus margin
    localparam int STALL_LIMIT  = 1000;   // cycles without any beat
    localparam int PHASE_BEATS  = 280;
    localparam int NUM_PHASES   = 5;
    localparam int SPEED_MAX    = 65535;
    localparam int SPEED_MIN    = -65536;
    localparam logic [psl_pkg::GAIN_W-1:0] GAIN_MAX = '1;
    localparam logic [psl_pkg::LIM_W-1:0]  LIM_MAX  = '1;

    // DUT ports
    logic                                i_clk            = 1'b0;
    logic                                i_rst_n          = 1'b0;
    logic                                i_cfg_valid      = 1'b0;
    logic                                o_cfg_ready;
    logic [psl_pkg::CFG_IDX_W-1:0]       i_cfg_index      = '0;
    logic [psl_pkg::CFG_DATA_W-1:0]      i_cfg_data       = '0;
    logic                                i_in_valid       = 1'b0;
    logic                                o_in_stall;
    logic signed [psl_pkg::IN_W-1:0]     i_target_speed   = '0;
    logic signed [psl_pkg::IN_W-1:0]     i_measured_speed = '0;
    logic                                i_clear          = 1'b0;
    logic                                o_out_valid;
    logic                                i_out_stall      = 1'b0;
    logic signed [psl_pkg::DRIVE_W-1:0]  o_drive;

    // Loop model: register copies and controller state
    logic [psl_pkg::GAIN_W-1:0]  kp        = psl_pkg::GAIN_PROP_RST;
    logic [psl_pkg::GAIN_W-1:0]  ki        = psl_pkg::GAIN_INT_RST;
    logic [psl_pkg::GAIN_W-1:0]  kd        = psl_pkg::GAIN_DER_RST;
    logic [psl_pkg::LIM_W-1:0]   drive_lim = psl_pkg::DRIVE_LIM_RST;
    logic [psl_pkg::LIM_W-1:0]   integ_lim = psl_pkg::INT_LIM_RST;
    longint                      integ_acc = 0;
    longint                      last_err  = 0;

    logic signed [psl_pkg::DRIVE_W-1:0] drive_expected_q[$];
    logic signed [psl_pkg::DRIVE_W-1:0] want_drive;

    int idle_pct        = 17;
    int bias            = 1;
    int mismatches      = 0;
    int beats_sent      = 0;
    int results_checked = 0;
    int cfg_writes      = 0;
    int hold_ticks      = 0;
    int clear_ticks     = 0;
    int quiet_cycles    = 0;

    pid_speed_loop_cond_antiwindup_unit DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_target_speed   (i_target_speed),
        .i_measured_speed (i_measured_speed),
        .i_clear          (i_clear),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_drive          (o_drive)
    );

    // 12 ns clock
    always #6 i_clk = ~i_clk;

    // One controller tick: returns the clamped drive and updates the state
    function automatic logic signed [psl_pkg::DRIVE_W-1:0] predict_drive(
        input logic signed [psl_pkg::IN_W-1:0] tgt,
        input logic signed [psl_pkg::IN_W-1:0] meas,
        input logic                            clr
    );
        longint err, pterm, dterm, preclip, ilim, olim, drv;
        bit     hold;
        if (clr) begin
            integ_acc = 0;
            last_err  = 0;
            clear_ticks++;
            return '0;
        end
        err  = longint'(tgt) - longint'(meas);
        ilim = longint'(integ_lim) * 256;
        olim = longint'(drive_lim) * 256;
        // >>> on a signed value floors toward minus infinity
        pterm   = (longint'(kp) * err) >>> psl_pkg::FRAC_W;
        dterm   = (longint'(kd) * (err - last_err)) >>> psl_pkg::FRAC_W;
        preclip = pterm + integ_acc + dterm;
        // skip integration when it would deepen saturation
        hold = (integ_acc >= ilim && err > 0) || (integ_acc <= -ilim && err < 0)
            || (preclip >= olim && err > 0) || (preclip <= -olim && err < 0);
        if (hold)
            hold_ticks++;
        else
            integ_acc += (longint'(ki) * err) >>> psl_pkg::FRAC_W;
        if (integ_acc >= ilim) integ_acc = ilim;
        if (integ_acc <= -ilim) integ_acc = -ilim;
        drv      = pterm + integ_acc + dterm;
        last_err = err;
        if (drv >= olim) drv = olim;
        if (drv <= -olim) drv = -olim;
        return psl_pkg::DRIVE_W'(drv);
    endfunction

    // Track register writes and predict every accepted input beat
    always @(posedge i_clk) begin
        if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                psl_pkg::REG_GAIN_PROP:      kp = i_cfg_data;
                psl_pkg::REG_GAIN_INTEGRAL:  ki = i_cfg_data;
                psl_pkg::REG_GAIN_DERIV:     kd = i_cfg_data;
                psl_pkg::REG_DRIVE_LIMIT:    drive_lim = i_cfg_data[psl_pkg::LIM_W-1:0];
                psl_pkg::REG_INTEGRAL_LIMIT: integ_lim = i_cfg_data[psl_pkg::LIM_W-1:0];
                default: ;
            endcase
            cfg_writes++;
        end
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            drive_expected_q.push_back(
                predict_drive(i_target_speed, i_measured_speed, i_clear));
            beats_sent++;
        end
    end

    // Compare each output beat with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (drive_expected_q.size() == 0) begin
                $display("%0t: drive beat %0d with nothing expected", $time, o_drive);
                mismatches++;
            end else begin
                want_drive = drive_expected_q.pop_front();
                if (o_drive !== want_drive) begin
                    $display("%0t: drive mismatch: expected %0d actual %0d",
                             $time, want_drive, o_drive);
                    mismatches++;
                end
            end
            results_checked++;
        end
    end

    // Random output stall
    always @(posedge i_clk)
        i_out_stall <= (idle_pct != 0) && ($urandom_range(99) < idle_pct);

    // Watchdog on cycles with no beat on any channel
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Send one beat; valid stays high after acceptance until the next call
    task automatic send_sample(input int tgt, input int meas, input bit clr);
        if ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        i_in_valid       <= 1'b1;
        i_target_speed   <= psl_pkg::IN_W'(tgt);
        i_measured_speed <= psl_pkg::IN_W'(meas);
        i_clear          <= clr;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Drop valid and let the pipeline empty
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (drive_expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [psl_pkg::CFG_IDX_W-1:0] idx,
                             input logic [psl_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Limits are written with random junk in the unused upper bits
    task automatic write_limits(input logic [psl_pkg::LIM_W-1:0] dlim,
                                input logic [psl_pkg::LIM_W-1:0] ilim);
        write_reg(psl_pkg::REG_DRIVE_LIMIT, {11'($urandom), dlim});
        write_reg(psl_pkg::REG_INTEGRAL_LIMIT, {11'($urandom), ilim});
    endtask

    function automatic logic [psl_pkg::GAIN_W-1:0] rand_gain();
        case ($urandom_range(9))
            0:       return '0;
            1:       return GAIN_MAX;
            default: return psl_pkg::GAIN_W'($urandom)
                            & ((psl_pkg::GAIN_W'(1) << $urandom_range(1, 23)) - 1);
        endcase
    endfunction

    function automatic logic [psl_pkg::LIM_W-1:0] rand_limit();
        case ($urandom_range(9))
            0:       return '0;
            1:       return LIM_MAX;
            2, 3:    return psl_pkg::LIM_W'($urandom_range(1, 64));
            default: return psl_pkg::LIM_W'($urandom_range(0, 8191));
        endcase
    endfunction

    // Reset values, extreme errors, clear and windup against both limits
    task automatic test_defaults();
        send_sample(0, 0, 0);
        send_sample(SPEED_MAX, SPEED_MIN, 0);
        send_sample(SPEED_MIN, SPEED_MAX, 0);
        send_sample(0, 0, 1);
        repeat (4) send_sample(64, 0, 0);
        repeat (4) send_sample(-64, 0, 0);
        send_sample(4096, 0, 0);
        send_sample(0, 4096, 0);
        send_sample(100, 100, 1);
        wait_idle();
    endtask

    // Output clamp tight, integral clamp wide: integration held by the drive
    task automatic test_drive_hold();
        write_limits(13'd10, LIM_MAX);
        repeat (2) send_sample(128, 0, 0);
        repeat (2) send_sample(1, 0, 0);
        wait_idle();
    endtask

    // Both limits zero hold the integral and the drive at zero
    task automatic test_zero_limits();
        write_limits('0, '0);
        send_sample(300, -300, 0);
        send_sample(-300, 300, 0);
        send_sample(5, 5, 0);
        wait_idle();
    endtask

    // Largest gains and limits with full-scale errors
    task automatic test_max_gains();
        write_reg(psl_pkg::REG_GAIN_PROP, GAIN_MAX);
        write_reg(psl_pkg::REG_GAIN_INTEGRAL, GAIN_MAX);
        write_reg(psl_pkg::REG_GAIN_DERIV, GAIN_MAX);
        write_limits(LIM_MAX, LIM_MAX);
        send_sample(SPEED_MAX, SPEED_MIN, 0);
        send_sample(SPEED_MIN, SPEED_MAX, 0);
        send_sample(SPEED_MAX, SPEED_MIN, 1);
        wait_idle();
    endtask

    // Writes to unused indexes must leave the registers alone
    task automatic test_unused_index();
        for (int idx = NUM_REGS; idx < (1 << psl_pkg::CFG_IDX_W); idx++)
            write_reg(psl_pkg::CFG_IDX_W'(idx), psl_pkg::CFG_DATA_W'($urandom));
        send_sample(700, -20, 0);
        send_sample(-900, 30, 0);
        wait_idle();
    endtask

    // Random phases; error runs drift in one direction to reach windup
    task automatic test_random_phases();
        int tgt, meas, sel;
        bit clr;
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph == 0) begin
                write_reg(psl_pkg::REG_GAIN_PROP, psl_pkg::GAIN_PROP_RST);
                write_reg(psl_pkg::REG_GAIN_INTEGRAL, psl_pkg::GAIN_INT_RST);
                write_reg(psl_pkg::REG_GAIN_DERIV, psl_pkg::GAIN_DER_RST);
                write_limits(psl_pkg::DRIVE_LIM_RST, psl_pkg::INT_LIM_RST);
            end else begin
                write_reg(psl_pkg::REG_GAIN_PROP, rand_gain());
                write_reg(psl_pkg::REG_GAIN_INTEGRAL, rand_gain());
                write_reg(psl_pkg::REG_GAIN_DERIV, rand_gain());
                if (ph == NUM_PHASES - 1)
                    write_limits(LIM_MAX, LIM_MAX);
                else
                    write_limits(rand_limit(), rand_limit());
            end
            // one phase runs with no gaps and no stalls
            idle_pct = (ph == 2) ? 0 : 17;
            for (int n = 0; n < PHASE_BEATS; n++) begin
                if ($urandom_range(19) == 0)
                    bias = -bias;
                sel  = $urandom_range(99);
                clr  = ($urandom_range(99) < 4);
                tgt  = $urandom_range(0, 131071) + SPEED_MIN;
                if (sel < 55) begin
                    meas = tgt - bias * $urandom_range(0, 255)
                           + $urandom_range(0, 63) - 32;
                    if (meas > SPEED_MAX) meas = SPEED_MAX;
                    if (meas < SPEED_MIN) meas = SPEED_MIN;
                end else if (sel < 90) begin
                    meas = $urandom_range(0, 131071) + SPEED_MIN;
                end else begin
                    tgt  = (bias > 0) ? SPEED_MAX : SPEED_MIN;
                    meas = (bias > 0) ? SPEED_MIN : SPEED_MAX;
                end
                send_sample(tgt, meas, clr);
            end
            wait_idle();
        end
        idle_pct = 17;
    endtask

    // Main sequence
    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_defaults();
        test_drive_hold();
        test_zero_limits();
        test_max_gains();
        test_unused_index();
        test_random_phases();
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (drive_expected_q.size() != 0) begin
            $display("%0t: %0d expected drive beats never arrived",
                     $time, drive_expected_q.size());
            mismatches += drive_expected_q.size();
        end
        $display("Run covered %0d input beats (%0d clears, %0d held integrations)",
                 beats_sent, clear_ticks, hold_ticks);
        $display("and %0d checked drive beats over %0d register writes",
                 results_checked, cfg_writes);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/psl_pkg.sv
rtl/core/psl_cfg_regs.sv
rtl/core/psl_front.sv
rtl/core/psl_back.sv
rtl/core/pid_speed_loop_cond_antiwindup_unit.sv
tb/pid_speed_loop_cond_antiwindup_unit_tb.sv
